// File: rtl/core/dtwrs_pkg.sv
`default_nettype none

package dtwrs_pkg;

  // Signed seconds-of-day arithmetic; wide enough for every window edge
  localparam int unsigned SecW = 19;
  typedef logic signed [SecW-1:0] sec_t;

  localparam sec_t DaySec  = sec_t'(86400);
  localparam sec_t HourSec = sec_t'(3600);
  localparam sec_t MinSec  = sec_t'(60);

  localparam int unsigned NumSlots = 5;
  localparam int unsigned SlotW    = 12;
  localparam int unsigned SchedW   = 61;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENABLED     = 3'd0,
    CFG_PRE_MIN     = 3'd1,
    CFG_FRI_PRE_MIN = 3'd2,
    CFG_ON_DLY_SEC  = 3'd3,
    CFG_OFF_DLY_MIN = 3'd4,
    CFG_EV_MASK     = 3'd5,
    CFG_SCHEDULE    = 3'd6
  } cfg_idx_t;

  // Event enable mask bit positions
  localparam int unsigned EvDawn      = 0;
  localparam int unsigned EvMidday    = 1;
  localparam int unsigned EvMiddayFri = 2;

  // Slot index of the midday event
  localparam int unsigned SlotMidday = 1;

  // Seconds of day for an hour, minute and second
  function automatic sec_t day_sec(logic [4:0] hour, logic [5:0] minute, logic [5:0] second);
    day_sec = sec_t'(hour) * HourSec + sec_t'(minute) * MinSec + sec_t'(second);
  endfunction

  // Window test, with the window clamped to one day
  function automatic logic in_window(sec_t now, sec_t start, sec_t stop);
    sec_t s;
    sec_t e;
    s = (start < 0) ? sec_t'(0) : start;
    e = (stop > DaySec) ? DaySec : stop;
    in_window = (s < e) && (now >= s) && (now < e);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/daily_time_window_relay_scheduler.sv
// Each accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle; an input register and a result register
// form a two-stage pipeline that stalls only on out_tready.
// Reset (rst_n low at a clock edge): pipeline emptied, relay state all off,
// configuration registers back to their defaults.
`default_nettype none

module daily_time_window_relay_scheduler
  import dtwrs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [23:0]         in_tdata,  // time_hour[4:0], time_minute[10:5],
                                              // time_second[16:11], is_friday[17], zero pad
  // Result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata, // relay_pair_on[0], relay_friday_on[1],
                                              // relay_lead_on[2], changed_mask[6:3], zero pad
  // Configuration write port
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [SchedW-1:0]   cfg_data
);

  // Configuration registers
  logic              enabled_r;
  logic [7:0]        pre_min_r;
  logic [7:0]        fri_pre_min_r;
  logic [13:0]       on_dly_sec_r;
  logic [7:0]        off_dly_min_r;
  logic [5:0]        ev_mask_r;
  logic [SchedW-1:0] sched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b1;
      pre_min_r     <= 8'd7;
      fri_pre_min_r <= 8'd40;
      on_dly_sec_r  <= 14'd2;
      off_dly_min_r <= 8'd5;
      ev_mask_r     <= 6'h3F;
      sched_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLED:     enabled_r     <= cfg_data[0];
        CFG_PRE_MIN:     pre_min_r     <= cfg_data[7:0];
        CFG_FRI_PRE_MIN: fri_pre_min_r <= cfg_data[7:0];
        CFG_ON_DLY_SEC:  on_dly_sec_r  <= cfg_data[13:0];
        CFG_OFF_DLY_MIN: off_dly_min_r <= cfg_data[7:0];
        CFG_EV_MASK:     ev_mask_r     <= cfg_data[5:0];
        CFG_SCHEDULE:    sched_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv) out_valid_r <= s1_valid_r;
    end
  end

  // Input register: capture the time word
  logic [4:0] hour_r;
  logic [5:0] minute_r;
  logic [5:0] second_r;
  logic       friday_r;

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      hour_r   <= in_tdata[4:0];
      minute_r <= in_tdata[10:5];
      second_r <= in_tdata[16:11];
      friday_r <= in_tdata[17];
    end
  end

  // Window evaluation over the five slots
  sec_t           now;
  sec_t           pre_sec;
  sec_t           fri_pre_sec;
  sec_t           off_sec;
  sec_t           on_dly;
  sec_t           ev_sec [NumSlots];
  logic           slot_on [NumSlots];
  logic           pair_nxt;
  logic           third_nxt;
  logic           lead_nxt;

  assign now         = day_sec(hour_r, minute_r, second_r);
  assign pre_sec     = sec_t'(pre_min_r) * MinSec;
  assign fri_pre_sec = sec_t'(fri_pre_min_r) * MinSec;
  assign off_sec     = sec_t'(off_dly_min_r) * MinSec;
  assign on_dly      = sec_t'(on_dly_sec_r);

  always_comb begin
    pair_nxt  = 1'b0;
    third_nxt = 1'b0;
    lead_nxt  = 1'b0;
    for (int k = 0; k < NumSlots; k++) begin
      ev_sec[k]  = day_sec(sched_r[SlotW*k+6 +: 5], sched_r[SlotW*k +: 6], 6'd0);
      slot_on[k] = enabled_r && sched_r[SchedW-1] && sched_r[SlotW*k+11];
    end
    // Dawn slot
    if (slot_on[0] && ev_mask_r[EvDawn]) begin
      if (in_window(now, ev_sec[0] - pre_sec, ev_sec[0])) lead_nxt = 1'b1;
      if (in_window(now, ev_sec[0] - pre_sec + on_dly, ev_sec[0] + off_sec)) pair_nxt = 1'b1;
    end
    // Midday slot: Friday rule or weekday rule
    if (slot_on[SlotMidday]) begin
      if (friday_r && ev_mask_r[EvMiddayFri]) begin
        if (in_window(now, ev_sec[SlotMidday] - fri_pre_sec, ev_sec[SlotMidday] - pre_sec))
          third_nxt = 1'b1;
        if (in_window(now, ev_sec[SlotMidday] - pre_sec, ev_sec[SlotMidday]))
          lead_nxt = 1'b1;
        if (in_window(now, ev_sec[SlotMidday] - fri_pre_sec + on_dly, ev_sec[SlotMidday]))
          pair_nxt = 1'b1;
      end else if (!friday_r && ev_mask_r[EvMidday]) begin
        if (in_window(now, ev_sec[SlotMidday] - pre_sec, ev_sec[SlotMidday]))
          lead_nxt = 1'b1;
        if (in_window(now, ev_sec[SlotMidday] - pre_sec + on_dly,
                      ev_sec[SlotMidday] + off_sec))
          pair_nxt = 1'b1;
      end
    end
    // Afternoon, sunset and night slots
    for (int k = 2; k < NumSlots; k++) begin
      if (slot_on[k] && ev_mask_r[k+1]) begin
        if (in_window(now, ev_sec[k] - pre_sec, ev_sec[k])) lead_nxt = 1'b1;
        if (in_window(now, ev_sec[k] - pre_sec + on_dly, ev_sec[k] + off_sec)) pair_nxt = 1'b1;
      end
    end
  end

  // Relay state and result register
  logic [3:0] relay_r;
  logic [3:0] relay_nxt;
  logic [7:0] out_data_r;

  assign relay_nxt = {lead_nxt, third_nxt, pair_nxt, pair_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r <= '0;
    end else if (s1_adv && s1_valid_r) begin
      relay_r <= relay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= {1'b0, relay_nxt ^ relay_r, lead_nxt, third_nxt, pair_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (relay_r == {out_data_r[2], out_data_r[1], out_data_r[0], out_data_r[0]}))
    else $error("relay state disagrees with result word");

  a_pair_change_twin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[3] == out_data_r[4]))
    else $error("paired relays reported different changes");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
